// ----- src/pse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 10;
  localparam int HIST_LEN  = 8;
  localparam int KEY_NUM   = 8;
  localparam int KEY_MAXW  = 9;
  localparam int KCNT_W    = 4;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  localparam logic [CFG_W-1:0] MIN_RUN_RESET = 10'd4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [HIST_LEN-1:0] hist_t;
  typedef logic [KCNT_W-1:0] kcnt_t;
  typedef logic [KEY_MAXW*BYTE_W-1:0] key_text_t;

  // text is right aligned: last character in the low byte
  localparam key_text_t KEY_TEXT [KEY_NUM] = '{
    key_text_t'("malware"),
    key_text_t'("trojan"),
    key_text_t'("virus"),
    key_text_t'("backdoor"),
    key_text_t'("keylog"),
    key_text_t'("ransom"),
    key_text_t'("exploit"),
    key_text_t'("shellcode")
  };

  localparam kcnt_t KEY_LEN [KEY_NUM] = '{
    4'd7, 4'd6, 4'd5, 4'd8, 4'd6, 4'd6, 4'd7, 4'd9
  };

  localparam kcnt_t KEY_MIN_LEN = 4'd5;

endpackage

`default_nettype wire

// ----- src/pse_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pse_match (
  input  wire pse_pkg::byte_t cur_byte,
  input  wire pse_pkg::hist_t recent,
  input  wire pse_pkg::kcnt_t run_cnt,
  output logic                hit
);
  import pse_pkg::*;

  logic [KEY_NUM-1:0] key_hit;

  always_comb begin
    byte_t win_b;
    for (int k = 0; k < KEY_NUM; k++) begin
      key_hit[k] = (run_cnt >= KEY_LEN[k]);
      for (int j = 0; j < KEY_MAXW; j++) begin
        win_b = (j == 0) ? cur_byte : recent[j-1];
        if (KCNT_W'(j) < KEY_LEN[k] && win_b != KEY_TEXT[k][BYTE_W*j +: BYTE_W]) begin
          key_hit[k] = 1'b0;
        end
      end
    end
  end

  assign hit = |key_hit;

endmodule

`default_nettype wire

// ----- src/printable_string_extractor_top.sv -----
// printable string extractor
// in_*: one dump byte per beat in in_tdata, in_tlast marks the final byte
// of the dump. after that byte all run state and the byte offset return to
// zero, so the next beat starts a new dump at offset zero.
// out_*: one beat per printable run (bytes 32..126) whose length reaches
// min_run_length (0 acts as 1). tdata holds start offset and saturating
// length, tuser says a keyword (malware, trojan, virus, backdoor, keylog,
// ransom, exploit, shellcode) lies wholly inside the run.
// cfg_*: writes min_run_length, always ready, reset value 4; write only
// while idle.
// throughput: one byte per cycle while in_tready is high. a run is reported
// when its closing byte moves from the input register to the output register.
// when the receiver stalls, the result waits in the output register; bytes
// that close no run keep flowing, and the next closing byte holds in the
// input register, which drops in_tready until the output register frees.
// reset (rst_n low, synchronous) empties both registers and clears state.
`timescale 1ns / 1ps
`default_nettype none

module printable_string_extractor_top #(
  parameter int OFFSET_BITS = 40,
  parameter int LENGTH_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [7:0]                   in_tdata,   // data_byte
  input  wire                          in_tlast,   // end_of_stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // start_offset, run_length, zero fill to whole bytes
  output logic [((OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0] out_tdata,
  output logic                         out_tuser,  // keyword_hit
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [pse_pkg::CFG_W-1:0]    cfg_data    // min_run_length
);
  import pse_pkg::*;

  localparam int OUT_W  = ((OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8;
  localparam int CMP_W  = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [CFG_W-1:0]       min_run_r;
  logic                   s1_valid_r;
  byte_t                  s1_byte_r;
  logic                   s1_eos_r;
  logic [OFFSET_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_BITS-1:0] run_start_r, run_start_nxt;
  logic [LENGTH_BITS-1:0] run_count_r, run_count_nxt;
  hist_t                  recent_r, recent_nxt;
  logic                   hit_flag_r, hit_flag_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] out_start_r;
  logic [LENGTH_BITS-1:0] out_len_r;
  logic                   out_hit_r;

  logic                   cur_print;
  logic [LENGTH_BITS-1:0] cnt_inc;
  kcnt_t                  key_cnt;
  logic                   hit_now;
  logic                   hit_after;
  logic [LENGTH_BITS-1:0] close_count;
  logic                   close_hit;
  logic [OFFSET_BITS-1:0] close_start;
  logic [CMP_W-1:0]       need;
  logic                   emit;
  logic                   s1_adv;

  assign cfg_ready = 1'b1;

  assign cur_print = (s1_byte_r >= PRINT_LO) && (s1_byte_r <= PRINT_HI);
  assign cnt_inc   = (run_count_r == LEN_MAX) ? run_count_r : run_count_r + 1'b1;
  assign key_cnt   = (cnt_inc > LENGTH_BITS'(4'hF)) ? 4'hF : cnt_inc[KCNT_W-1:0];

  pse_match u_match (
    .cur_byte (s1_byte_r),
    .recent   (recent_r),
    .run_cnt  (key_cnt),
    .hit      (hit_now)
  );

  assign hit_after   = ((run_count_r != '0) && hit_flag_r) || hit_now;
  assign close_count = cur_print ? cnt_inc : run_count_r;
  assign close_hit   = cur_print ? hit_after : hit_flag_r;
  assign close_start = (cur_print && run_count_r == '0) ? byte_offset_r : run_start_r;
  assign need        = (min_run_r == '0) ? CMP_W'(1) : CMP_W'(min_run_r);
  assign emit        = (!cur_print || s1_eos_r) && (close_count != '0)
                       && (CMP_W'(close_count) >= need);

  assign s1_adv    = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    byte_offset_nxt = byte_offset_r + 1'b1;
    recent_nxt      = {recent_r[HIST_LEN-2:0], s1_byte_r};
    run_start_nxt   = close_start;
    if (s1_eos_r) begin
      byte_offset_nxt = '0;
      recent_nxt      = '0;
      run_start_nxt   = '0;
      run_count_nxt   = '0;
      hit_flag_nxt    = 1'b0;
    end else if (cur_print) begin
      run_count_nxt = cnt_inc;
      hit_flag_nxt  = hit_after;
    end else begin
      run_count_nxt = '0;
      hit_flag_nxt  = 1'b0;
    end
  end

  assign out_valid_nxt = (s1_adv && emit) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r     <= MIN_RUN_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      byte_offset_r <= '0;
      run_start_r   <= '0;
      run_count_r   <= '0;
      recent_r      <= '0;
      hit_flag_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_run_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        byte_offset_r <= byte_offset_nxt;
        run_start_r   <= run_start_nxt;
        run_count_r   <= run_count_nxt;
        recent_r      <= recent_nxt;
        hit_flag_r    <= hit_flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_eos_r  <= in_tlast;
    end
    if (s1_adv && emit) begin
      out_start_r <= close_start;
      out_len_r   <= close_count;
      out_hit_r   <= close_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_len_r, out_start_r});
  assign out_tuser  = out_hit_r;

`ifndef SYNTH
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("reported run has zero length");

  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_len_r >= LENGTH_BITS'(KEY_MIN_LEN)))
    else $error("keyword flagged in a run shorter than any keyword");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eos_r) |=> (byte_offset_r == '0 && run_count_r == '0))
    else $error("state not cleared after end of stream");

  a_break_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !cur_print) |=> (run_count_r == '0 && !hit_flag_r))
    else $error("run still open after a non-printable byte");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_start_r) && $stable(out_len_r))
    else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
